// ===== sv/adcseq_pkg.sv =====
// adcseq_pkg: shared types and constants for the parallel converter read sequencer
// phase encoding, register map, configuration and result records
// no dependencies
package adcseq_pkg;

   // fixed field widths
   localparam int BUS_W      = 16;
   localparam int TIMER_W    = 16;
   localparam int CH_IDX_W   = 3;
   localparam int CHCNT_W    = 4;
   localparam int TOCNT_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [TIMER_W-1:0] CONVST_LOW_RST   = 16'd500;
   localparam logic [TIMER_W-1:0] BUSY_BLANK_RST   = 16'd10;
   localparam logic [TIMER_W-1:0] BUSY_TIMEOUT_RST = 16'd1000;
   localparam logic [TIMER_W-1:0] CS_SETUP_RST     = 16'd10;
   localparam logic [TIMER_W-1:0] RD_LOW_RST       = 16'd20;
   localparam logic [TIMER_W-1:0] RD_HIGH_RST      = 16'd20;
   localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CONVST = 3'd1,
      PH_BLANK  = 3'd2,
      PH_BUSY   = 3'd3,
      PH_SETUP  = 3'd4,
      PH_RDLOW  = 3'd5,
      PH_RDHIGH = 3'd6
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CONVST_LOW    = 3'd0,
      REG_BUSY_BLANK    = 3'd1,
      REG_BUSY_TIMEOUT  = 3'd2,
      REG_CS_SETUP      = 3'd3,
      REG_RD_LOW        = 3'd4,
      REG_RD_HIGH       = 3'd5,
      REG_CHANNEL_COUNT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TIMER_W-1:0] convst_low;
      logic [TIMER_W-1:0] busy_blank;
      logic [TIMER_W-1:0] busy_timeout;
      logic [TIMER_W-1:0] cs_setup;
      logic [TIMER_W-1:0] rd_low;
      logic [TIMER_W-1:0] rd_high;
      logic [CHCNT_W-1:0] channel_count;
   } cfg_type;

   typedef struct packed {
      logic                convst_n;
      logic                cs_n;
      logic                rd_n;
      logic                idle;
      logic                sample_valid;
      logic [BUS_W-1:0]    sample_value;
      logic [CH_IDX_W-1:0] channel_index;
      logic                last_channel;
      logic                timeout_event;
      logic [TOCNT_W-1:0]  timeout_total;
   } result_type;

endpackage

// ===== sv/adcseq_req_if.sv =====
// adcseq_req_if: input item channel, one item per clock tick of the pin sequencer
// carries start request, busy level and the data bus
// depends on adcseq_pkg
interface adcseq_req_if;
   import adcseq_pkg::*;

   logic             valid;
   logic             ready;
   logic             start_request;
   logic             busy_level;
   logic [BUS_W-1:0] data_bus;

   modport source (output valid, output start_request, output busy_level, output data_bus,
                   input ready);
   modport sink   (input valid, input start_request, input busy_level, input data_bus,
                   output ready);
endinterface

// ===== sv/adcseq_rsp_if.sv =====
// adcseq_rsp_if: result item channel, pin drives and sample of one tick
// depends on adcseq_pkg
interface adcseq_rsp_if;
   import adcseq_pkg::*;

   logic                valid;
   logic                ready;
   logic                convst_n;
   logic                cs_n;
   logic                rd_n;
   logic                idle;
   logic                sample_valid;
   logic [BUS_W-1:0]    sample_value;
   logic [CH_IDX_W-1:0] channel_index;
   logic                last_channel;
   logic                timeout_event;
   logic [TOCNT_W-1:0]  timeout_total;

   modport source (output valid, output convst_n, output cs_n, output rd_n, output idle,
                   output sample_valid, output sample_value, output channel_index,
                   output last_channel, output timeout_event, output timeout_total,
                   input ready);
   modport sink   (input valid, input convst_n, input cs_n, input rd_n, input idle,
                   input sample_valid, input sample_value, input channel_index,
                   input last_channel, input timeout_event, input timeout_total,
                   output ready);
endinterface

// ===== sv/adcseq_csr_if.sv =====
// adcseq_csr_if: register write channel, index and write data
// depends on adcseq_pkg
interface adcseq_csr_if;
   import adcseq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/parallel_adc_convert_read_sequencer.sv =====
// parallel_adc_convert_read_sequencer: top level of the parallel converter read sequencer
// register file, sequencer core and a one-deep result register
// depends on adcseq_pkg, adcseq_req_if, adcseq_rsp_if, adcseq_csr_if, adcseq_core
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while the receiver takes results; the result register reloads while drained
// reset: registers take their default timings, the sequencer returns to idle with its
//   timer, channel counter and timeout count at zero, and no result is pending
module parallel_adc_convert_read_sequencer #(
   parameter int MAX_CHANNELS = 8,
   parameter int BUS_WIDTH    = 16
) (
   input logic          clock,
   input logic          reset,
   adcseq_req_if.sink   req_chan,
   adcseq_rsp_if.source rsp_chan,
   adcseq_csr_if.sink   csr_chan
);
   import adcseq_pkg::*;

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type core_result;

   logic       req_accept;
   logic       csr_write;

   // register port never stalls; the user must write only while the sequencer is quiet, the block does not enforce it
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_chan.index)
            REG_CONVST_LOW:    cfg_in.convst_low    = csr_chan.data;
            REG_BUSY_BLANK:    cfg_in.busy_blank    = csr_chan.data;
            REG_BUSY_TIMEOUT:  cfg_in.busy_timeout  = csr_chan.data;
            REG_CS_SETUP:      cfg_in.cs_setup      = csr_chan.data;
            REG_RD_LOW:        cfg_in.rd_low        = csr_chan.data;
            REG_RD_HIGH:       cfg_in.rd_high       = csr_chan.data;
            REG_CHANNEL_COUNT: cfg_in.channel_count = csr_chan.data[CHCNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.convst_low    <= CONVST_LOW_RST;
         cfg_ff.busy_blank    <= BUSY_BLANK_RST;
         cfg_ff.busy_timeout  <= BUSY_TIMEOUT_RST;
         cfg_ff.cs_setup      <= CS_SETUP_RST;
         cfg_ff.rd_low        <= RD_LOW_RST;
         cfg_ff.rd_high       <= RD_HIGH_RST;
         cfg_ff.channel_count <= CHANNEL_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // an item is taken whenever the result register is empty or being drained this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // sequencer core advances exactly one tick per accepted item
   adcseq_core #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .BUS_WIDTH    (BUS_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (req_accept),
      .start_request (req_chan.start_request),
      .busy_level    (req_chan.busy_level),
      .data_bus      (req_chan.data_bus),
      .cfg           (cfg_ff),
      .result        (core_result)
   );

   // result register: loads on accept, empties once taken
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload carries no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.convst_n      = rsp_data_ff.convst_n;
   assign rsp_chan.cs_n          = rsp_data_ff.cs_n;
   assign rsp_chan.rd_n          = rsp_data_ff.rd_n;
   assign rsp_chan.idle          = rsp_data_ff.idle;
   assign rsp_chan.sample_valid  = rsp_data_ff.sample_valid;
   assign rsp_chan.sample_value  = rsp_data_ff.sample_value;
   assign rsp_chan.channel_index = rsp_data_ff.channel_index;
   assign rsp_chan.last_channel  = rsp_data_ff.last_channel;
   assign rsp_chan.timeout_event = rsp_data_ff.timeout_event;
   assign rsp_chan.timeout_total = rsp_data_ff.timeout_total;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_cfg_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_chan.index == REG_CONVST_LOW
      |=> cfg_ff.convst_low == $past(csr_chan.data))
      else $error("convert-start low time write lost");

   a_reset_empties: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid_ff)
      else $error("result pending straight after reset");
`endif

endmodule

// ===== sv/adcseq_core.sv =====
// adcseq_core: phase state machine, phase timer, channel and timeout counters
// advances one tick per step and gives that tick's result combinationally
// depends on adcseq_pkg
module adcseq_core #(
   parameter int MAX_CHANNELS = 8,
   parameter int BUS_WIDTH    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             start_request,
   input  logic                             busy_level,
   input  logic [adcseq_pkg::BUS_W-1:0]     data_bus,
   input  adcseq_pkg::cfg_type              cfg,
   output adcseq_pkg::result_type           result
);
   import adcseq_pkg::*;

   localparam int CNT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int EFF_W = CHCNT_W + 1;

   phase_type            phase_ff, phase_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic [CNT_W-1:0]     chan_ff, chan_in;
   logic [TOCNT_W-1:0]   tocnt_ff, tocnt_in;

   logic [EFF_W-1:0]     eff_chans;
   logic [EFF_W-1:0]     chan_plus1;
   logic                 last_chan;
   logic [TIMER_W:0]     timer_inc;
   logic [TIMER_W-1:0]   phase_dur;
   logic                 timer_done;
   logic                 timed_out;
   logic [BUS_W-1:0]     bus_masked;

   // channel count: zero reads one, above the maximum saturates
   always_comb begin
      if (cfg.channel_count == '0) begin
         eff_chans = EFF_W'(1);
      end else if ({1'b0, cfg.channel_count} > EFF_W'(MAX_CHANNELS)) begin
         eff_chans = EFF_W'(MAX_CHANNELS);
      end else begin
         eff_chans = {1'b0, cfg.channel_count};
      end
   end

   assign chan_plus1 = EFF_W'(chan_ff) + EFF_W'(1);
   assign last_chan  = chan_plus1 >= eff_chans;

   // duration of the current timed phase, zero behaves as one tick
   always_comb begin
      case (phase_ff)
         PH_CONVST: phase_dur = cfg.convst_low;
         PH_BLANK:  phase_dur = cfg.busy_blank;
         PH_SETUP:  phase_dur = cfg.cs_setup;
         PH_RDLOW:  phase_dur = cfg.rd_low;
         PH_RDHIGH: phase_dur = cfg.rd_high;
         default:   phase_dur = '0;
      endcase
   end

   assign timer_inc  = {1'b0, timer_ff} + (TIMER_W+1)'(1);
   assign timer_done = timer_inc >= {1'b0, phase_dur};
   assign timed_out  = timer_ff >= cfg.busy_timeout;
   assign bus_masked = BUS_W'(data_bus[BUS_WIDTH-1:0]);

   // next state
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      chan_in  = chan_ff;
      tocnt_in = tocnt_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               phase_in = PH_CONVST;
               timer_in = '0;
            end
         end
         PH_CONVST: begin
            if (timer_done) begin
               phase_in = PH_BLANK;
               timer_in = '0;
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         PH_BLANK: begin
            if (timer_done) begin
               phase_in = PH_BUSY;
               timer_in = '0;
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         PH_BUSY: begin
            if (!busy_level) begin
               phase_in = PH_SETUP;
               timer_in = '0;
            end else if (timed_out) begin
               tocnt_in = tocnt_ff + TOCNT_W'(1);
               phase_in = PH_SETUP;
               timer_in = '0;
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         PH_SETUP: begin
            if (timer_done) begin
               phase_in = PH_RDLOW;
               timer_in = '0;
               chan_in  = '0;
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         PH_RDLOW: begin
            if (timer_done) begin
               phase_in = PH_RDHIGH;
               timer_in = '0;
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         PH_RDHIGH: begin
            if (timer_done) begin
               timer_in = '0;
               if (last_chan) begin
                  phase_in = PH_IDLE;
                  chan_in  = '0;
               end else begin
                  phase_in = PH_RDLOW;
                  chan_in  = chan_ff + CNT_W'(1);
               end
            end else begin
               timer_in = timer_inc[TIMER_W-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
            timer_in = '0;
         end
      endcase
   end

   // outputs: pins follow the phase held at the start of the tick
   always_comb begin
      result               = '0;
      result.convst_n      = (phase_ff != PH_CONVST);
      result.cs_n          = !((phase_ff == PH_SETUP) || (phase_ff == PH_RDLOW) ||
                               (phase_ff == PH_RDHIGH));
      result.rd_n          = (phase_ff != PH_RDLOW);
      result.idle          = (phase_ff == PH_IDLE);
      result.timeout_event = (phase_ff == PH_BUSY) && busy_level && timed_out;
      result.timeout_total = tocnt_in;
      if ((phase_ff == PH_RDLOW) && timer_done) begin
         result.sample_valid  = 1'b1;
         result.sample_value  = bus_masked;
         result.channel_index = CH_IDX_W'(chan_ff);
         result.last_channel  = last_chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         chan_ff  <= '0;
         tocnt_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         chan_ff  <= chan_in;
         tocnt_ff <= tocnt_in;
      end
   end

`ifndef SYNTHESIS
   a_timeout_counts: assert property (@(posedge clock) disable iff (reset)
      step && result.timeout_event |=> tocnt_ff == $past(tocnt_ff) + TOCNT_W'(1))
      else $error("timeout count did not advance on a timeout");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(timer_ff) && $stable(chan_ff))
      else $error("sequencer state moved without an item");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0 && chan_ff == '0)
      else $error("timer or channel counter left set in idle");
`endif

endmodule

// ===== sim/adcseq_checker.sv =====
// adcseq_checker: watches the item, result and register channels of the converter read
// sequencer, predicts every result tick and compares it field by field
// depends on adcseq_pkg and the adcseq_req_if, adcseq_rsp_if and adcseq_csr_if interfaces
module adcseq_checker
   import adcseq_pkg::*;
#(
   parameter int MAX_CHANNELS = 8,
   parameter int BUS_WIDTH    = 16
) (
   input  logic  clock,
   input  logic  reset,
   input  logic  wrap_up,
   adcseq_req_if req_mon,
   adcseq_rsp_if rsp_mon,
   adcseq_csr_if csr_mon,
   output int    fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [BUS_W-1:0] BUS_MASK = {BUS_W{1'b1}} >> (BUS_W - BUS_WIDTH);

   cfg_type           cfg_regs;
   phase_type         seq_phase;
   logic [TIMER_W-1:0] phase_ticks;
   logic [3:0]        chan_ctr;
   logic [TOCNT_W-1:0] timeout_tally;
   result_type        expected_results[$];
   int                errors = 0;
   bit                wrapped_up = 1'b0;

   assign fail_count = errors;

   // a zero length counts as one tick
   function automatic logic timer_done(input logic [TIMER_W-1:0] length);
      int ticks_needed;
      ticks_needed = (length == '0) ? 1 : int'(length);
      if (int'(phase_ticks) + 1 >= ticks_needed) begin
         phase_ticks = '0;
         return 1'b1;
      end
      phase_ticks = phase_ticks + 1'b1;
      return 1'b0;
   endfunction

   function automatic int channels_read();
      int count;
      count = int'(cfg_regs.channel_count);
      if (count == 0) count = 1;
      if (count > MAX_CHANNELS) count = MAX_CHANNELS;
      return count;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_regs      = '{convst_low: CONVST_LOW_RST, busy_blank: BUSY_BLANK_RST,
                           busy_timeout: BUSY_TIMEOUT_RST, cs_setup: CS_SETUP_RST,
                           rd_low: RD_LOW_RST, rd_high: RD_HIGH_RST,
                           channel_count: CHANNEL_COUNT_RST};
         seq_phase     = PH_IDLE;
         phase_ticks   = '0;
         chan_ctr      = '0;
         timeout_tally = '0;
         expected_results.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_CONVST_LOW:    cfg_regs.convst_low    = csr_mon.data;
               REG_BUSY_BLANK:    cfg_regs.busy_blank    = csr_mon.data;
               REG_BUSY_TIMEOUT:  cfg_regs.busy_timeout  = csr_mon.data;
               REG_CS_SETUP:      cfg_regs.cs_setup      = csr_mon.data;
               REG_RD_LOW:        cfg_regs.rd_low        = csr_mon.data;
               REG_RD_HIGH:       cfg_regs.rd_high       = csr_mon.data;
               REG_CHANNEL_COUNT: cfg_regs.channel_count = csr_mon.data[CHCNT_W-1:0];
               default: ;
            endcase
         end

         // compare before predicting, so a result in the same cycle as its item is caught
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no expectation waiting: idle %0b, sample_valid %0b",
                      rsp_mon.idle, rsp_mon.sample_valid);
               errors++;
            end else begin
               want = expected_results.pop_front();
               compare_field("convst_n", want.convst_n, rsp_mon.convst_n);
               compare_field("cs_n", want.cs_n, rsp_mon.cs_n);
               compare_field("rd_n", want.rd_n, rsp_mon.rd_n);
               compare_field("idle", want.idle, rsp_mon.idle);
               compare_field("sample_valid", want.sample_valid, rsp_mon.sample_valid);
               compare_field("sample_value", want.sample_value, rsp_mon.sample_value);
               compare_field("channel_index", want.channel_index, rsp_mon.channel_index);
               compare_field("last_channel", want.last_channel, rsp_mon.last_channel);
               compare_field("timeout_event", want.timeout_event, rsp_mon.timeout_event);
               compare_field("timeout_total", want.timeout_total, rsp_mon.timeout_total);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            // pin levels come from the phase held at the start of the tick
            want          = '0;
            want.convst_n = (seq_phase != PH_CONVST);
            want.cs_n     = !(seq_phase == PH_SETUP || seq_phase == PH_RDLOW ||
                              seq_phase == PH_RDHIGH);
            want.rd_n     = (seq_phase != PH_RDLOW);
            want.idle     = (seq_phase == PH_IDLE);
            case (seq_phase)
               PH_IDLE: begin
                  if (req_mon.start_request) begin
                     seq_phase   = PH_CONVST;
                     phase_ticks = '0;
                  end
               end
               PH_CONVST: if (timer_done(cfg_regs.convst_low)) seq_phase = PH_BLANK;
               PH_BLANK:  if (timer_done(cfg_regs.busy_blank)) seq_phase = PH_BUSY;
               PH_BUSY: begin
                  if (!req_mon.busy_level) begin
                     seq_phase   = PH_SETUP;
                     phase_ticks = '0;
                  end else if (phase_ticks >= cfg_regs.busy_timeout) begin
                     timeout_tally      = timeout_tally + 1'b1;
                     want.timeout_event = 1'b1;
                     seq_phase          = PH_SETUP;
                     phase_ticks        = '0;
                  end else begin
                     phase_ticks = phase_ticks + 1'b1;
                  end
               end
               PH_SETUP: begin
                  if (timer_done(cfg_regs.cs_setup)) begin
                     seq_phase = PH_RDLOW;
                     chan_ctr  = '0;
                  end
               end
               PH_RDLOW: begin
                  if (timer_done(cfg_regs.rd_low)) begin
                     want.sample_valid  = 1'b1;
                     want.sample_value  = req_mon.data_bus & BUS_MASK;
                     want.channel_index = chan_ctr[CH_IDX_W-1:0];
                     want.last_channel  = (int'(chan_ctr) + 1 >= channels_read());
                     seq_phase          = PH_RDHIGH;
                  end
               end
               PH_RDHIGH: begin
                  if (timer_done(cfg_regs.rd_high)) begin
                     if (int'(chan_ctr) + 1 >= channels_read()) begin
                        seq_phase = PH_IDLE;
                        chan_ctr  = '0;
                     end else begin
                        chan_ctr  = chan_ctr + 1'b1;
                        seq_phase = PH_RDLOW;
                     end
                  end
               end
               default: begin
                  seq_phase   = PH_IDLE;
                  phase_ticks = '0;
               end
            endcase
            want.timeout_total = timeout_tally;
            expected_results.push_back(want);
         end

         if (wrap_up && !wrapped_up) begin
            wrapped_up = 1'b1;
            if (expected_results.size() != 0) begin
               $error("%0d expected results never arrived", expected_results.size());
               errors += expected_results.size();
            end
         end
      end
   end
endmodule

// ===== sim/tb_top.sv =====
// tb_top: stimulus and verdict for the parallel converter read sequencer
// drives start, busy and bus ticks plus register writes; adcseq_checker does the prediction
// depends on adcseq_pkg, the three channel interfaces, adcseq_checker and the block itself
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import adcseq_pkg::*;

   localparam int MAX_CH         = 8;
   localparam int BUS_BITS       = 16;
   localparam int STALL_PCT      = 8;     // chance per cycle that either side idles
   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off to back the block up
   localparam int RANDOM_ITEMS   = 100;
   localparam int DRAIN_GRACE    = 5;     // grace after the last result, for anything stray
   // longest correct stretch without any handshake is one hold-off plus a few stalls
   localparam int WATCHDOG_LIMIT = 2000;
   // index past the end of the register map, the block must ignore it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   logic    clock   = 1'b0;
   logic    reset   = 1'b1;
   logic    wrap_up = 1'b0;
   int      fail_count;

   // shadow of the timings last written, used to shape busy and start
   cfg_type settings;
   bit      steady   = 1'b0;   // no idling on either side while set
   int      hold_ask = 0;      // bumped to ask the receiver for one long hold-off
   int      sent_items = 0;

   // bookkeeping from the result side
   int      rsp_count        = 0;
   int      last_idle_result = -1;
   int      stuck_cycles     = 0;

   always #5ns clock = ~clock;

   adcseq_req_if req_if ();
   adcseq_rsp_if rsp_if ();
   adcseq_csr_if csr_if ();

   parallel_adc_convert_read_sequencer #(
      .MAX_CHANNELS (MAX_CH),
      .BUS_WIDTH    (BUS_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   adcseq_checker #(
      .MAX_CHANNELS (MAX_CH),
      .BUS_WIDTH    (BUS_BITS)
   ) seq_check (
      .clock      (clock),
      .reset      (reset),
      .wrap_up    (wrap_up),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .fail_count (fail_count)
   );

   // a zero length register behaves as one tick
   function automatic int ticks_of(input logic [TIMER_W-1:0] length);
      return (length == '0) ? 1 : int'(length);
   endfunction

   // bus words lean on the extremes now and then
   function automatic logic [BUS_W-1:0] rand_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return BUS_W'($urandom);
      endcase
   endfunction

   // mostly tiny timings so that many conversions fit, with zero and some longer ones
   function automatic logic [TIMER_W-1:0] short_time();
      case ($urandom_range(9))
         0:       return '0;
         7, 8:    return TIMER_W'($urandom_range(5, 12));
         9:       return TIMER_W'($urandom_range(13, 40));
         default: return TIMER_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type plan;
      plan.convst_low    = short_time();
      plan.busy_blank    = short_time();
      plan.busy_timeout  = short_time();
      plan.cs_setup      = short_time();
      plan.rd_low        = short_time();
      plan.rd_high       = short_time();
      plan.channel_count = CHCNT_W'($urandom_range(15));
      return plan;
   endfunction

   // every timing the same, own busy timeout and channel count
   function automatic cfg_type flat_plan(input logic [TIMER_W-1:0] timing,
                                         input logic [TIMER_W-1:0] wait_limit,
                                         input logic [CHCNT_W-1:0] chans);
      return '{convst_low: timing, busy_blank: timing, busy_timeout: wait_limit,
               cs_setup: timing, rd_low: timing, rd_high: timing, channel_count: chans};
   endfunction

   // one tick offered to the block; returns at the edge where it is taken
   task automatic send_item(input logic start_bit, input logic busy_bit,
                            input logic [BUS_W-1:0] word);
      if (!steady && $urandom_range(99) < STALL_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.start_request <= start_bit;
      req_if.busy_level    <= busy_bit;
      req_if.data_bus      <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_items++;
   endtask

   // stop offering and wait for every result to come back
   task automatic settle();
      req_if.valid <= 1'b0;
      while (rsp_count < sent_items) @(posedge clock);
   endtask

   // writes all seven registers back to back, optionally the unused index as well
   task automatic write_settings(input cfg_type plan, input bit poke_spare);
      logic [CSR_IDX_W-1:0]  reg_index [8];
      logic [CSR_DATA_W-1:0] reg_value [8];
      int                    writes;
      reg_index[0] = REG_CONVST_LOW;    reg_value[0] = plan.convst_low;
      reg_index[1] = REG_BUSY_BLANK;    reg_value[1] = plan.busy_blank;
      reg_index[2] = REG_BUSY_TIMEOUT;  reg_value[2] = plan.busy_timeout;
      reg_index[3] = REG_CS_SETUP;      reg_value[3] = plan.cs_setup;
      reg_index[4] = REG_RD_LOW;        reg_value[4] = plan.rd_low;
      reg_index[5] = REG_RD_HIGH;       reg_value[5] = plan.rd_high;
      // junk above the count field must be dropped by the block
      reg_index[6] = REG_CHANNEL_COUNT;
      reg_value[6] = {(CSR_DATA_W - CHCNT_W)'($urandom), plan.channel_count};
      reg_index[7] = REG_SPARE;         reg_value[7] = CSR_DATA_W'($urandom);
      writes = poke_spare ? 8 : 7;
      for (int k = 0; k < writes; k++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= reg_index[k];
         csr_if.data  <= reg_value[k];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
      end
      csr_if.valid <= 1'b0;
      settings = plan;
   endtask

   // one full conversion from a start tick until a result shows the sequencer idle again;
   // busy stays high for busy_extra polls, so busy_extra above the timeout forces a timeout
   task automatic convert_once(input int busy_extra, input bit noisy);
      int   busy_until;
      int   ticks_in;
      int   mark;
      int   tick_cap;
      logic busy_now;
      logic start_now;
      busy_until = ticks_of(settings.convst_low) + ticks_of(settings.busy_blank) + busy_extra;
      // a conversion that runs far past its longest possible length has hung
      tick_cap   = 4 * (ticks_of(settings.convst_low) + ticks_of(settings.busy_blank) +
                        int'(settings.busy_timeout) + 1 + ticks_of(settings.cs_setup) +
                        MAX_CH * (ticks_of(settings.rd_low) + ticks_of(settings.rd_high)))
                   + 100;
      send_item(1'b1, 1'b1, rand_word());
      mark     = sent_items;
      ticks_in = 0;
      while (last_idle_result < mark) begin
         ticks_in++;
         if (ticks_in > tick_cap) begin
            $display("CHECK FAILED");
            $finish;
         end
         busy_now = (ticks_in <= busy_until);
         // glitches on busy now and then, an early fall just ends the wait sooner
         if (noisy && $urandom_range(24) == 0) busy_now = ~busy_now;
         // stray starts only while convert-start is certainly still low, so they are ignored
         start_now = (ticks_in <= ticks_of(settings.convst_low)) && ($urandom_range(1) == 1);
         send_item(start_now, busy_now, rand_word());
      end
   endtask

   // result receiver: random single-cycle stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_taken;
      hold_left    = 0;
      hold_taken   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_ask) begin
            hold_taken = hold_ask;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
         end
      end
   end

   // result bookkeeping and the watchdog
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         if (rsp_if.idle) last_idle_result <= rsp_count;
         rsp_count <= rsp_count + 1;
      end
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      cfg_type plan;
      int      phase_no;
      int      random_from;

      // every block input at a known level from time zero
      req_if.valid         = 1'b0;
      req_if.start_request = 1'b0;
      req_if.busy_level    = 1'b0;
      req_if.data_bus      = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = REG_CONVST_LOW;
      csr_if.data          = '0;
      settings = '{convst_low: CONVST_LOW_RST, busy_blank: BUSY_BLANK_RST,
                   busy_timeout: BUSY_TIMEOUT_RST, cs_setup: CS_SETUP_RST,
                   rd_low: RD_LOW_RST, rd_high: RD_HIGH_RST,
                   channel_count: CHANNEL_COUNT_RST};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // idle ticks without a start, bus at both extremes
      send_item(1'b0, 1'b0, '0);
      send_item(1'b0, 1'b1, '1);
      settle();

      // reset timings with a single channel, busy falls well inside the window;
      // run without idling on either side for one long unbroken stretch
      csr_if.valid <= 1'b1;
      csr_if.index <= REG_CHANNEL_COUNT;
      csr_if.data  <= CSR_DATA_W'(1);
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      settings.channel_count = 4'd1;
      steady = 1'b1;
      convert_once(2, 1'b0);
      steady = 1'b0;
      settle();

      // shortest legal timings, one channel; busy falls at once, then on the last allowed poll
      write_settings(flat_plan(16'd1, 16'd1, 4'd1), 1'b1);
      convert_once(0, 1'b0);
      convert_once(1, 1'b0);
      settle();

      // all registers zero: one-tick phases, one channel, first busy-high poll times out
      write_settings(flat_plan(16'd0, 16'd0, 4'd0), 1'b0);
      convert_once(1, 1'b0);
      convert_once(0, 1'b0);
      settle();

      // channel count above the maximum saturates; busy just inside, then just past, its limit;
      // the receiver holds off while ticks keep being offered
      write_settings(flat_plan(16'd2, 16'd3, 4'd15), 1'b0);
      hold_ask++;
      convert_once(3, 1'b0);
      convert_once(4, 1'b0);
      settle();

      // busy timeout at its maximum, busy falls after a few polls
      write_settings(flat_plan(16'd1, 16'hFFFF, 4'd1), 1'b0);
      convert_once(5, 1'b0);
      settle();

      // random timings per phase, a few conversions each with idle ticks in between
      random_from = sent_items;
      phase_no    = 0;
      while (sent_items - random_from < RANDOM_ITEMS) begin
         plan = random_settings();
         write_settings(plan, $urandom_range(3) == 0);
         // a stretch of phases with no idling on either side
         steady = (phase_no >= 6 && phase_no < 10);
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(3)) send_item(1'b0, 1'($urandom_range(1)), rand_word());
            // now and then the receiver holds off while ticks keep being offered
            if (phase_no % 5 == 2) hold_ask++;
            convert_once($urandom_range(int'(plan.busy_timeout) + 2), 1'b1);
         end
         settle();
         phase_no++;
      end
      steady = 1'b0;

      // all results are in; leave a little time for anything stray, then close the books
      repeat (DRAIN_GRACE) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/adcseq_pkg.sv
sv/adcseq_req_if.sv
sv/adcseq_rsp_if.sv
sv/adcseq_csr_if.sv
sv/adcseq_core.sv
sv/parallel_adc_convert_read_sequencer.sv
sim/adcseq_checker.sv
sim/tb_top.sv
